// ===== hdl/bra_pkg.sv =====
// shared types and constants of the bitmap run allocator
package bra_pkg;

  localparam int unsigned MODE_W    = 3;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned BIDX_W    = 13;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BYTE_W    = BIDX_W - 3;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_SET      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_CLR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_SET = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TEST     = 3'd4;

  // byte store access from the sequencer
  typedef struct packed {
    logic                 wr_en;
    logic [BYTE_W-1:0]    wr_byte;
    logic [BYTE_BITS-1:0] wr_data;
    logic [BYTE_W-1:0]    rd_byte;
  } mem_req_t;

endpackage

// ===== hdl/bitmap_run_allocator_top.sv =====
// bitmap run allocator: set, clear, first-fit run search and bit test
// a request is accepted, set up, walks its map bytes unless trivial, then gives its result
// a new request is taken only after the previous one has left its result state, so the
// byte walk over the map memory sets the rate; a stalled result holds that state
// after reset the map is swept to zero byte by byte with in_stall high
// active_bits resets to 4096; config writes are taken at any time
module bitmap_run_allocator_top import bra_pkg::*; #(
  parameter int unsigned MAX_BITS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [CNT_W-1:0]  in_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [POS_W-1:0]  out_run_start,
  output logic              out_bit_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_active_bits
);

  // map storage in bytes, last byte may be partly used
  localparam int unsigned STORE_BYTES = (MAX_BITS + 7) / 8;

  logic [CNT_W-1:0]     active_bits_r;
  logic [BIDX_W-1:0]    size;
  mem_req_t             mem_req;
  logic [BYTE_BITS-1:0] mem_rd_data;
  logic                 mem_busy;

  // size register, the sequencer latches the walk limit at setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bits_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_bits_r <= cfg_active_bits;
    end
  end

  assign cfg_ready = 1'b1;

  // effective size clamps at the map capacity
  assign size = (32'(active_bits_r) > MAX_BITS) ? BIDX_W'(MAX_BITS) : active_bits_r;

  bra_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  // sequencer also holds the result register, so a finished beat waits there
  // while the next request is accepted
  bra_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_run_start (out_run_start),
    .out_bit_value (out_bit_value),
    .size          (size),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .mem_busy      (mem_busy)
  );

endmodule

// ===== hdl/bra_store.sv =====
// byte-wide bitmap memory with registered read and clearing pass after reset
module bra_store import bra_pkg::*; #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mem_req_t             req,
  output logic [BYTE_BITS-1:0] rd_data,
  output logic                 busy
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [BYTE_BITS-1:0] mem [DEPTH];
  logic [BYTE_BITS-1:0] rd_data_r;
  logic                 clearing_r;
  logic [AW-1:0]        clr_addr_r;

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[AW'(req.wr_byte)] <= req.wr_data;
    end
    rd_data_r <= mem[AW'(req.rd_byte)];
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

// ===== hdl/bra_seq.sv =====
// request sequencer: walks the map one byte per cycle, read-modify-write, run search or bit test
module bra_seq import bra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [POS_W-1:0]     in_position,
  input  logic [CNT_W-1:0]     in_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [POS_W-1:0]     out_run_start,
  output logic                 out_bit_value,
  input  logic [BIDX_W-1:0]    size,
  output mem_req_t             mem_req,
  input  logic [BYTE_BITS-1:0] mem_rd_data,
  input  logic                 mem_busy
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_SCAN, S_DONE} state_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       k;
    logic [CNT_W-1:0] run;
  } scan_t;

  // bit-serial run count over one byte, bits lo up to hi-1
  function automatic scan_t scan_byte(input logic [BYTE_BITS-1:0] d,
                                      input logic [2:0] lo, input logic [3:0] hi,
                                      input logic want,
                                      input logic [CNT_W-1:0] run_in,
                                      input logic [CNT_W-1:0] cnt);
    scan_t res;
    res.hit = 1'b0;
    res.k   = '0;
    res.run = run_in;
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (!res.hit && (4'(k) >= {1'b0, lo}) && (4'(k) < hi)) begin
        if (d[k] == want) begin
          res.run = res.run + 1'b1;
        end else begin
          res.run = '0;
        end
        if (res.run == cnt) begin
          res.hit = 1'b1;
          res.k   = 3'(k);
        end
      end
    end
    return res;
  endfunction

  state_t              state_r;
  logic [MODE_W-1:0]   mode_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [BIDX_W-1:0]   limit_r;
  logic [BYTE_W-1:0]   last_byte_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [CNT_W-1:0]    run_r;
  logic                found_r;
  logic                bit_r;
  logic [BIDX_W-1:0]   hit_idx_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [POS_W-1:0]    out_run_start_r;
  logic                out_bit_value_r;

  logic                is_write;
  logic                is_find;
  logic                trivial;
  logic [BIDX_W-1:0]   pos_ext;
  logic [BIDX_W:0]     run_end;
  logic [BIDX_W-1:0]   limit_nxt;
  logic [BYTE_W-1:0]   pos_byte;
  logic [2:0]          lo;
  logic [3:0]          hi;
  logic                last;
  logic [BYTE_BITS-1:0] mask;
  scan_t               scan;
  logic [BIDX_W-1:0]   start_full;

  assign is_write = (mode_r == MODE_SET) || (mode_r == MODE_CLEAR);
  assign is_find  = (mode_r == MODE_FIND_CLR) || (mode_r == MODE_FIND_SET);
  assign pos_ext  = BIDX_W'(pos_r);
  assign pos_byte = pos_r[POS_W-1:3];
  // one extra bit so a long count past the map end cannot wrap
  assign run_end  = {1'b0, pos_ext} + {1'b0, cnt_r};

  always_comb begin
    trivial = 1'b0;
    if (!is_write && !is_find && mode_r != MODE_TEST) begin
      trivial = 1'b1;
    end else if (pos_ext >= size) begin
      trivial = 1'b1;
    end else if (mode_r != MODE_TEST && cnt_r == '0) begin
      trivial = 1'b1;
    end
  end

  always_comb begin
    if (mode_r == MODE_TEST) begin
      limit_nxt = pos_ext + 1'b1;
    end else if (is_find || run_end > {1'b0, size}) begin
      limit_nxt = size;
    end else begin
      limit_nxt = run_end[BIDX_W-1:0];
    end
  end

  // bit window of the current byte
  assign last = (byte_r == last_byte_r);
  assign lo   = (byte_r == pos_byte) ? pos_r[2:0] : 3'd0;
  assign hi   = (last && limit_r[2:0] != 3'd0) ? {1'b0, limit_r[2:0]} : 4'd8;

  always_comb begin
    for (int k = 0; k < BYTE_BITS; k++) begin
      mask[k] = (4'(k) >= {1'b0, lo}) && (4'(k) < hi);
    end
  end

  assign scan = scan_byte(mem_rd_data, lo, hi, (mode_r == MODE_FIND_SET), run_r, cnt_r);

  always_comb begin
    mem_req.wr_en   = (state_r == S_SCAN) && is_write;
    mem_req.wr_byte = byte_r;
    mem_req.wr_data = (mode_r == MODE_SET) ? (mem_rd_data | mask) : (mem_rd_data & ~mask);
    mem_req.rd_byte = (state_r == S_SETUP) ? pos_byte : byte_r + 1'b1;
  end

  assign start_full = hit_idx_r + 1'b1 - cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !mem_busy) begin
            mode_r  <= in_mode;
            pos_r   <= in_position;
            cnt_r   <= in_count;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          found_r     <= 1'b0;
          bit_r       <= 1'b0;
          run_r       <= '0;
          byte_r      <= pos_byte;
          limit_r     <= limit_nxt;
          last_byte_r <= BYTE_W'((limit_nxt - 1'b1) >> 3);
          state_r     <= trivial ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (mode_r == MODE_TEST) begin
            bit_r   <= mem_rd_data[pos_r[2:0]];
            state_r <= S_DONE;
          end else if (is_find && scan.hit) begin
            found_r   <= 1'b1;
            hit_idx_r <= {byte_r, scan.k};
            state_r   <= S_DONE;
          end else if (last) begin
            state_r <= S_DONE;
          end else begin
            run_r  <= scan.run;
            byte_r <= byte_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r     <= 1'b1;
            out_found_r     <= found_r;
            out_run_start_r <= found_r ? start_full[POS_W-1:0] : '0;
            out_bit_value_r <= bit_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE) || mem_busy;
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_run_start = out_run_start_r;
  assign out_bit_value = out_bit_value_r;

endmodule

// ===== sim/tb_bitmap_run_allocator_top.sv =====
// self-checking testbench for the bitmap run allocator top level
module tb_bitmap_run_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bra_pkg::*;

  localparam int unsigned MAP_BITS       = 4096;
  localparam int unsigned SEG_ITEMS      = 195;    // six segments, about 1170 requests
  localparam int unsigned WATCHDOG_LIMIT = 20000;  // well above the length of a full map walk
  localparam int unsigned TAIL_CYCLES    = MAP_BITS / 8 + 8;

  // mode codes the block has no use for, they must come back all zero
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] run_start;
    logic             bit_value;
  } alloc_result_t;

  // a run handed out by an allocate sequence, freed later
  typedef struct {
    int unsigned base;
    int unsigned len;
  } alloc_span_t;

  // bit-level copy of the map plus the queue of results still owed
  class allocator_scoreboard;
    bit [MAP_BITS-1:0] map_bits;
    int unsigned       active_bits;
    alloc_result_t     pending_results[$];
    int unsigned       error_count;

    function new();
      map_bits    = '0;
      active_bits = ACTIVE_RESET;
      error_count = 0;
    endfunction

    function int unsigned map_size();
      return (active_bits > MAP_BITS) ? MAP_BITS : active_bits;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void take_active_bits(logic [CNT_W-1:0] value);
      active_bits = value;
    endfunction

    // writes clip at the active size, out-of-map starts and zero counts do nothing
    function void fill_run(int unsigned from, int unsigned len, bit value);
      int unsigned stop;
      if (from >= map_size() || len == 0) return;
      stop = from + len;
      if (stop > map_size()) stop = map_size();
      for (int unsigned i = from; i < stop; i++) map_bits[i] = value;
    endfunction

    // plain bit walk, the byte-wise walk inside the block gives the same answer
    function bit search_run(int unsigned from, int unsigned len, bit want,
                            output int unsigned hit);
      int unsigned run;
      run = 0;
      hit = 0;
      if (len == 0) return 1'b0;
      for (int unsigned i = from; i < map_size(); i++) begin
        if (map_bits[i] == want) run++;
        else run = 0;
        if (run == len) begin
          hit = i + 1 - len;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function alloc_result_t note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                         logic [CNT_W-1:0] cnt);
      alloc_result_t res;
      int unsigned   hit;
      res = '0;
      case (mode)
        MODE_SET:   fill_run(pos, cnt, 1'b1);
        MODE_CLEAR: fill_run(pos, cnt, 1'b0);
        MODE_FIND_CLR, MODE_FIND_SET: begin
          res.found = search_run(pos, cnt, mode == MODE_FIND_SET, hit);
          if (res.found) res.run_start = POS_W'(hit);
        end
        MODE_TEST: begin
          if (pos < map_size()) res.bit_value = map_bits[pos];
        end
        default: ;
      endcase
      pending_results.push_back(res);
      return res;
    endfunction

    function void report(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual found=%0d run_start=%0d bit=%0d",
                 $time, got.found, got.run_start, got.bit_value);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.run_start !== want.run_start) report("run_start", want.run_start, got.run_start);
      if (got.bit_value !== want.bit_value) report("bit_value", want.bit_value, got.bit_value);
    endfunction
  endclass

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode         = MODE_TEST;
  logic [POS_W-1:0]  in_position     = '0;
  logic [CNT_W-1:0]  in_count        = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_found;
  logic [POS_W-1:0]  out_run_start;
  logic              out_bit_value;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_active_bits = ACTIVE_RESET;

  allocator_scoreboard sb = new();
  alloc_span_t         live_spans[$];   // runs currently handed out
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         issued         = 0;  // requests sent so far

  bitmap_run_allocator_top #(.MAX_BITS(MAP_BITS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_count        (in_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_run_start   (out_run_start),
    .out_bit_value   (out_bit_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_active_bits (cfg_active_bits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // every result beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_found, out_run_start, out_bit_value});
    end
  end

  // ends the run when no beat moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // present one request, with random idle cycles ahead of it, and hold it until taken
  // in_valid is left high on return so a following request can go out back to back
  task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                               input logic [CNT_W-1:0] cnt, output alloc_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_count    <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = sb.note_request(mode, pos, cnt);
    issued++;
  endtask

  // drop valid in the step of the last accept, then wait for every owed result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic load_active_bits(input logic [CNT_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_active_bits <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.take_active_bits(value);
    cfg_valid <= 1'b0;
  endtask

  // search starts lean toward the bottom of the map, as first-fit users do
  function automatic logic [POS_W-1:0] pos_in_map(int unsigned size);
    if (size == 0) return POS_W'($urandom_range(MAP_BITS - 1));
    if ($urandom_range(1) == 0) return '0;
    return POS_W'($urandom_range(size - 1));
  endfunction

  // mostly short runs; the wide form adds zero, oversized and huge counts
  function automatic logic [CNT_W-1:0] run_length(bit wide);
    int unsigned r;
    r = $urandom_range(99);
    if (wide && r < 8) begin
      if (r < 3) return '0;
      if (r < 5) return '1;
      return CNT_W'($urandom_range(8191));
    end
    if (r < 65) return CNT_W'($urandom_range(8, 1));
    if (r < 92) return CNT_W'($urandom_range(64, 9));
    if (r < 99 || !wide) return CNT_W'($urandom_range(512, 65));
    return CNT_W'($urandom_range(MAP_BITS, 513));
  endfunction

  initial begin : stimulus
    alloc_result_t    res;
    alloc_span_t      span;
    logic [CNT_W-1:0] seg_sizes[6];
    logic [CNT_W-1:0] len;
    int unsigned      size;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      target;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests on the reset size of 4096 bits
    send_idle_pct  = 22;
    recv_stall_pct = 53;
    issue_request(MODE_TEST, 12'd0, 13'd0, res);          // cleared after reset
    issue_request(MODE_SET, 12'd0, 13'd1, res);
    issue_request(MODE_TEST, 12'd0, 13'd8191, res);
    issue_request(MODE_SET, 12'd4095, 13'd1, res);        // last bit of the map
    issue_request(MODE_TEST, 12'd4095, 13'd0, res);
    issue_request(MODE_FIND_CLR, 12'd0, 13'd1, res);
    issue_request(MODE_FIND_SET, 12'd1, 13'd1, res);      // long walk over clear bytes
    issue_request(MODE_FIND_CLR, 12'd0, 13'd0, res);      // zero count finds nothing
    issue_request(MODE_SET, 12'd5, 13'd0, res);           // zero count writes nothing
    issue_request(MODE_SET, 12'd4000, 13'd8191, res);     // clipped at the map end
    issue_request(MODE_FIND_SET, 12'd3990, 13'd96, res);
    issue_request(MODE_FIND_SET, 12'd3000, 13'd97, res);  // runs off the end, no run
    issue_request(MODE_CLEAR, 12'd0, 13'd4096, res);
    issue_request(MODE_FIND_CLR, 12'd0, 13'd4096, res);   // whole map as one run
    issue_request(MODE_SET, 12'd13, 13'd19, res);         // unaligned, spans bytes
    issue_request(MODE_FIND_SET, 12'd0, 13'd19, res);
    issue_request(MODE_FIND_CLR, 12'd13, 13'd3, res);     // restarts after the set run
    issue_request(MODE_SPARE5, 12'd4095, 13'd8191, res);
    issue_request(MODE_SPARE6, 12'd0, 13'd0, res);
    issue_request(MODE_SPARE7, 12'd2730, 13'd5461, res);

    // zero size puts every position outside the map
    wait_results_drained();
    load_active_bits(13'd0);
    issue_request(MODE_TEST, 12'd13, 13'd0, res);
    issue_request(MODE_FIND_CLR, 12'd0, 13'd1, res);

    // one-bit map: writes clip after bit 0
    wait_results_drained();
    load_active_bits(13'd1);
    issue_request(MODE_SET, 12'd0, 13'd10, res);
    issue_request(MODE_TEST, 12'd1, 13'd0, res);

    // oversized register acts as the full map, bit 1 stayed clear
    wait_results_drained();
    load_active_bits(13'd8191);
    issue_request(MODE_TEST, 12'd1, 13'd0, res);

    seg_sizes[0] = ACTIVE_RESET;
    seg_sizes[1] = CNT_W'($urandom_range(64, 1));
    seg_sizes[2] = 13'd8191;
    seg_sizes[3] = CNT_W'($urandom_range(MAP_BITS, 65));
    seg_sizes[4] = ACTIVE_RESET;
    seg_sizes[5] = CNT_W'($urandom_range(1500, 200));

    // three idling phases, two map sizes each; resizing keeps the stored bits
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 22 : (ph == 1) ? 53 : 0;
      recv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 22 : 0;
      for (int sg = 0; sg < 2; sg++) begin
        wait_results_drained();
        load_active_bits(seg_sizes[ph * 2 + sg]);
        size   = sb.map_size();
        target = issued + SEG_ITEMS;
        while (issued < target) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            // allocate: first-fit search, then claim what it found
            len = run_length(1'b0);
            issue_request(MODE_FIND_CLR, pos_in_map(size), len, res);
            if (res.found) begin
              span.base = res.run_start;
              span.len  = len;
              live_spans.push_back(span);
              issue_request(MODE_SET, res.run_start, len, res);
            end
          end else if (pick < 65 && live_spans.size() != 0) begin
            // free: look the run up, probe one bit of it, release it
            idx  = $urandom_range(live_spans.size() - 1);
            span = live_spans[idx];
            live_spans.delete(idx);
            if ($urandom_range(1) == 0) begin
              issue_request(MODE_FIND_SET, POS_W'(span.base), CNT_W'(span.len), res);
            end
            issue_request(MODE_TEST, POS_W'(span.base + $urandom_range(span.len - 1)),
                          CNT_W'($urandom), res);
            issue_request(MODE_CLEAR, POS_W'(span.base), CNT_W'(span.len), res);
          end else if (pick < 75) begin
            issue_request(MODE_TEST, pos_in_map(size), CNT_W'($urandom), res);
          end else begin
            // noise: any mode, starts past the map, extreme counts
            issue_request(MODE_W'($urandom_range(7)),
                          ($urandom_range(4) == 0) ? POS_W'($urandom) : pos_in_map(size),
                          run_length(1'b1), res);
          end
        end
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== bitmap_run_allocator_top.f =====
hdl/bra_pkg.sv
hdl/bra_store.sv
hdl/bra_seq.sv
hdl/bitmap_run_allocator_top.sv
sim/tb_bitmap_run_allocator_top.sv
